FILE: rtl/nwnf_pkg.sv
// shared types and constants for the normal-weighted neighbour filter
// no dependencies; used by nwnf_sqrt and normal_weighted_neighbour_filter
package nwnf_pkg;

    localparam int SQ_IN_W   = 56;   // squared offset length, Q.40
    localparam int SQ_ROOT_W = SQ_IN_W / 2;
    localparam int SQ_REM_W  = SQ_ROOT_W + 2;
    localparam int C2_W      = 19;   // squared clamped normal dot product, Q.15

    localparam logic [15:0] ONE_Q15 = 16'h8000;

    typedef enum logic [0:0] {
        CFG_INV_RADIUS = 1'b0,
        CFG_KEEP_THR   = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic signed [15:0] first_x;
        logic signed [15:0] first_y;
        logic signed [15:0] first_z;
        logic signed [15:0] first_nx;
        logic signed [15:0] first_ny;
        logic signed [15:0] first_nz;
        logic signed [15:0] second_x;
        logic signed [15:0] second_y;
        logic signed [15:0] second_z;
        logic signed [15:0] second_nx;
        logic signed [15:0] second_ny;
        logic signed [15:0] second_nz;
    } t_in;

    typedef struct packed {
        logic [15:0] pair_weight;
        logic        keep;
    } t_out;

    // side band carried alongside the square root pipeline
    typedef struct packed {
        logic            vld;
        logic [C2_W-1:0] c2;
    } t_sq_tag;

endpackage

FILE: rtl/nwnf_sqrt.sv
// pipelined floor integer square root for both directions, one result bit per stage
// depends on nwnf_pkg
module nwnf_sqrt import nwnf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic [SQ_IN_W-1:0]   i_rad [2],
    input  t_sq_tag              i_tag,
    output logic [SQ_ROOT_W-1:0] o_root [2],
    output t_sq_tag              o_tag
);

    logic [SQ_IN_W-1:0]   r_rad  [SQ_ROOT_W][2];
    logic [SQ_REM_W-1:0]  r_rem  [SQ_ROOT_W][2];
    logic [SQ_ROOT_W-1:0] r_root [SQ_ROOT_W][2];
    t_sq_tag              r_tag  [SQ_ROOT_W];

    logic [SQ_IN_W-1:0]   n_rad  [SQ_ROOT_W][2];
    logic [SQ_REM_W-1:0]  n_rem  [SQ_ROOT_W][2];
    logic [SQ_ROOT_W-1:0] n_root [SQ_ROOT_W][2];

    logic [SQ_IN_W-1:0]   s_rad  [SQ_ROOT_W][2];
    logic [SQ_REM_W-1:0]  s_rem  [SQ_ROOT_W][2];
    logic [SQ_ROOT_W-1:0] s_root [SQ_ROOT_W][2];
    logic [SQ_REM_W+1:0]  s_pre  [SQ_ROOT_W][2];
    logic [SQ_REM_W+1:0]  s_trial[SQ_ROOT_W][2];

    always_comb begin
        for (int d = 0; d < 2; d++) begin
            s_rad[0][d]  = i_rad[d];
            s_rem[0][d]  = '0;
            s_root[0][d] = '0;
            for (int g = 1; g < SQ_ROOT_W; g++) begin
                s_rad[g][d]  = r_rad[g-1][d];
                s_rem[g][d]  = r_rem[g-1][d];
                s_root[g][d] = r_root[g-1][d];
            end
        end
        for (int g = 0; g < SQ_ROOT_W; g++) begin
            for (int d = 0; d < 2; d++) begin
                s_pre[g][d]   = {s_rem[g][d], s_rad[g][d][SQ_IN_W-1 -: 2]};
                s_trial[g][d] = {2'b00, s_root[g][d], 2'b01};
                n_rad[g][d]   = s_rad[g][d] << 2;
                if (s_pre[g][d] >= s_trial[g][d]) begin
                    n_rem[g][d]  = SQ_REM_W'(s_pre[g][d] - s_trial[g][d]);
                    n_root[g][d] = {s_root[g][d][SQ_ROOT_W-2:0], 1'b1};
                end else begin
                    n_rem[g][d]  = s_pre[g][d][SQ_REM_W-1:0];
                    n_root[g][d] = {s_root[g][d][SQ_ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int g = 0; g < SQ_ROOT_W; g++) begin
                for (int d = 0; d < 2; d++) begin
                    r_rad[g][d]  <= n_rad[g][d];
                    r_rem[g][d]  <= n_rem[g][d];
                    r_root[g][d] <= n_root[g][d];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < SQ_ROOT_W; g++) begin
                r_tag[g].vld <= 1'b0;
            end
        end else if (i_en) begin
            r_tag[0] <= i_tag;
            for (int g = 1; g < SQ_ROOT_W; g++) begin
                r_tag[g] <= r_tag[g-1];
            end
        end
    end

    assign o_root[0] = r_root[SQ_ROOT_W-1][0];
    assign o_root[1] = r_root[SQ_ROOT_W-1][1];
    assign o_tag     = r_tag[SQ_ROOT_W-1];

endmodule

FILE: rtl/normal_weighted_neighbour_filter.sv
// normal-weighted neighbour filter: pipelined from input to output transaction
// throughput one pair per cycle unless stalled; 28 of the stages are the bit-serial square root pipeline
// the whole pipeline advances together and holds while the output register is not taken
// synchronous active-low reset clears valid bits and restores inv_radius and keep_threshold
// depends on nwnf_pkg and nwnf_sqrt
module normal_weighted_neighbour_filter import nwnf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in         i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out        o_data,
    input  logic        i_cfg_we,
    input  t_cfg_idx    i_cfg_idx,
    input  logic [15:0] i_cfg_wdata
);

    logic en;

    logic [15:0] r_inv_radius;
    logic [15:0] r_thr;

    logic r1_v, r2_v, r3_v, r4_v, r5_v, r6_v;
    logic r7_v, r8_v, r9_v, r10_v, r11_v, r12_v, r13_v, r14_v;
    logic r_out_vld;
    t_out r_out;

    logic signed [16:0] r1_dv [3];
    logic signed [15:0] r1_n1 [3];
    logic signed [15:0] r1_n2 [3];
    logic signed [31:0] r1_nn [3];

    logic signed [34:0] r2_proj [2];
    logic signed [16:0] r2_dv [3];
    logic signed [15:0] r2_n1 [3];
    logic signed [15:0] r2_n2 [3];
    logic        [17:0] r2_c;

    logic signed [50:0] r3_pn [2][3];
    logic signed [16:0] r3_dv [3];
    logic        [35:0] r3_cc;

    logic signed [26:0] r4_e [2][3];
    logic [C2_W-1:0]    r4_c2;

    logic [53:0]        r5_sqr [2][3];
    logic [C2_W-1:0]    r5_c2;

    logic [SQ_IN_W-1:0] r6_sq [2];
    logic [C2_W-1:0]    r6_c2;

    logic [SQ_ROOT_W-1:0] sq_root [2];
    t_sq_tag              sq_tag_in;
    t_sq_tag              sq_tag_out;

    logic [43:0]     r7_lr [2];
    logic [C2_W-1:0] r7_c2;
    logic [15:0]     r8_d [2];
    logic            r8_big [2];
    logic [C2_W-1:0] r8_c2;
    logic [31:0]     r9_dd [2];
    logic [15:0]     r9_d [2];
    logic            r9_big [2];
    logic [C2_W-1:0] r9_c2;
    logic [15:0]     r10_d2 [2];
    logic [15:0]     r10_d [2];
    logic            r10_big [2];
    logic [C2_W-1:0] r10_c2;
    logic [31:0]     r11_d3p [2];
    logic [15:0]     r11_d2 [2];
    logic            r11_big [2];
    logic [C2_W-1:0] r11_c2;
    logic [15:0]     r12_k [2];
    logic [C2_W-1:0] r12_c2;
    logic [34:0]     r13_kc [2];
    logic [20:0]     r14_w [2];

    logic signed [34:0] n2_proj [2];
    logic signed [33:0] n2_dot;
    logic        [17:0] n2_c;
    logic signed [51:0] n4_e45 [2][3];
    logic [31:0]        n8_dist [2];
    logic [15:0]        n12_d3 [2];
    logic [19:0]        n12_kr [2];
    logic [15:0]        n12_k [2];
    logic [20:0]        n_wmin;
    t_out               n_out;

    assign en      = !r_out_vld || i_ready;
    assign o_ready = en;
    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_radius <= 16'd2560;
            r_thr        <= 16'd328;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_INV_RADIUS: r_inv_radius <= i_cfg_wdata;
                CFG_KEEP_THR:   r_thr        <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v      <= 1'b0;
            r2_v      <= 1'b0;
            r3_v      <= 1'b0;
            r4_v      <= 1'b0;
            r5_v      <= 1'b0;
            r6_v      <= 1'b0;
            r7_v      <= 1'b0;
            r8_v      <= 1'b0;
            r9_v      <= 1'b0;
            r10_v     <= 1'b0;
            r11_v     <= 1'b0;
            r12_v     <= 1'b0;
            r13_v     <= 1'b0;
            r14_v     <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r1_v      <= i_valid;
            r2_v      <= r1_v;
            r3_v      <= r2_v;
            r4_v      <= r3_v;
            r5_v      <= r4_v;
            r6_v      <= r5_v;
            r7_v      <= sq_tag_out.vld;
            r8_v      <= r7_v;
            r9_v      <= r8_v;
            r10_v     <= r9_v;
            r11_v     <= r10_v;
            r12_v     <= r11_v;
            r13_v     <= r12_v;
            r14_v     <= r13_v;
            r_out_vld <= r14_v;
        end
    end

    always_comb begin
        n2_proj[0] = '0;
        n2_proj[1] = '0;
        n2_dot     = '0;
        for (int i = 0; i < 3; i++) begin
            n2_proj[0] = n2_proj[0] + 35'(r1_dv[i]) * 35'(r1_n1[i]);
            n2_proj[1] = n2_proj[1] - 35'(r1_dv[i]) * 35'(r1_n2[i]);
            n2_dot     = n2_dot + 34'(r1_nn[i]);
        end
        n2_c = n2_dot[33] ? '0 : 18'((n2_dot + 34'sd16384) >>> 15);
    end

    // offset plus twice its projection, rounded to Q.20
    always_comb begin
        for (int d = 0; d < 2; d++) begin
            for (int i = 0; i < 3; i++) begin
                n4_e45[d][i] = ((d == 0) ? (52'(r3_dv[i]) <<< 30) : -(52'(r3_dv[i]) <<< 30))
                               + (52'(r3_pn[d][i]) <<< 1);
            end
        end
    end

    always_comb begin
        for (int d = 0; d < 2; d++) begin
            n8_dist[d] = 32'((r7_lr[d] + 44'd4096) >> 13);
            n12_d3[d]  = 16'((r11_d3p[d] + 32'd16384) >> 15);
            // kernel 2d^3 - 3d^2 + 1 in Q.15, kept to [0, 1]
            n12_kr[d]  = 20'd32768 + (20'(n12_d3[d]) << 1) - 20'(r11_d2[d]) * 20'd3;
            if (r11_big[d] || n12_kr[d][19]) begin
                n12_k[d] = '0;
            end else if (n12_kr[d] > 20'd32768) begin
                n12_k[d] = ONE_Q15;
            end else begin
                n12_k[d] = n12_kr[d][15:0];
            end
        end
    end

    always_comb begin
        n_wmin = (r14_w[0] < r14_w[1]) ? r14_w[0] : r14_w[1];
        n_out.pair_weight = (n_wmin > 21'(ONE_Q15)) ? ONE_Q15 : n_wmin[15:0];
        n_out.keep        = n_out.pair_weight > r_thr;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_dv[0] <= 17'(i_data.first_x) - 17'(i_data.second_x);
            r1_dv[1] <= 17'(i_data.first_y) - 17'(i_data.second_y);
            r1_dv[2] <= 17'(i_data.first_z) - 17'(i_data.second_z);
            r1_n1[0] <= i_data.first_nx;
            r1_n1[1] <= i_data.first_ny;
            r1_n1[2] <= i_data.first_nz;
            r1_n2[0] <= i_data.second_nx;
            r1_n2[1] <= i_data.second_ny;
            r1_n2[2] <= i_data.second_nz;
            r1_nn[0] <= 32'(i_data.first_nx) * 32'(i_data.second_nx);
            r1_nn[1] <= 32'(i_data.first_ny) * 32'(i_data.second_ny);
            r1_nn[2] <= 32'(i_data.first_nz) * 32'(i_data.second_nz);

            r2_proj <= n2_proj;
            r2_dv   <= r1_dv;
            r2_n1   <= r1_n1;
            r2_n2   <= r1_n2;
            r2_c    <= n2_c;

            for (int i = 0; i < 3; i++) begin
                r3_pn[0][i] <= 51'(r2_proj[0]) * 51'(r2_n1[i]);
                r3_pn[1][i] <= 51'(r2_proj[1]) * 51'(r2_n2[i]);
            end
            r3_dv <= r2_dv;
            r3_cc <= 36'(r2_c) * 36'(r2_c);

            for (int d = 0; d < 2; d++) begin
                for (int i = 0; i < 3; i++) begin
                    r4_e[d][i] <= 27'((n4_e45[d][i] + 52'sd16777216) >>> 25);
                end
            end
            r4_c2 <= C2_W'((r3_cc + 36'd16384) >> 15);

            for (int d = 0; d < 2; d++) begin
                for (int i = 0; i < 3; i++) begin
                    r5_sqr[d][i] <= 54'(r4_e[d][i]) * 54'(r4_e[d][i]);
                end
            end
            r5_c2 <= r4_c2;

            for (int d = 0; d < 2; d++) begin
                r6_sq[d] <= SQ_IN_W'(r5_sqr[d][0]) + SQ_IN_W'(r5_sqr[d][1])
                          + SQ_IN_W'(r5_sqr[d][2]);
            end
            r6_c2 <= r5_c2;

            for (int d = 0; d < 2; d++) begin
                r7_lr[d]   <= 44'(sq_root[d]) * 44'(r_inv_radius);
                r8_d[d]    <= n8_dist[d][15:0];
                r8_big[d]  <= n8_dist[d] > 32'(ONE_Q15);
                r9_dd[d]   <= 32'(r8_d[d]) * 32'(r8_d[d]);
                r9_d[d]    <= r8_d[d];
                r9_big[d]  <= r8_big[d];
                r10_d2[d]  <= 16'((r9_dd[d] + 32'd16384) >> 15);
                r10_d[d]   <= r9_d[d];
                r10_big[d] <= r9_big[d];
                r11_d3p[d] <= 32'(r10_d2[d]) * 32'(r10_d[d]);
                r11_d2[d]  <= r10_d2[d];
                r11_big[d] <= r10_big[d];
                r12_k[d]   <= n12_k[d];
                r13_kc[d]  <= 35'(r12_k[d]) * 35'(r12_c2);
                r14_w[d]   <= 21'((r13_kc[d] + 35'd16384) >> 15);
            end
            r7_c2  <= sq_tag_out.c2;
            r8_c2  <= r7_c2;
            r9_c2  <= r8_c2;
            r10_c2 <= r9_c2;
            r11_c2 <= r10_c2;
            r12_c2 <= r11_c2;

            r_out <= n_out;
        end
    end

    assign sq_tag_in.vld = r6_v;
    assign sq_tag_in.c2  = r6_c2;

    nwnf_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_rad   (r6_sq),
        .i_tag   (sq_tag_in),
        .o_root  (sq_root),
        .o_tag   (sq_tag_out)
    );

    // weight stays within [0, 1]
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.pair_weight <= ONE_Q15))
        else $error("pair weight above one");

    // distance beyond the radius gives a zero kernel
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r11_v && r11_big[0]) |=> (r12_k[0] == '0))
        else $error("kernel not zero outside radius");

    // a bubble in the last stage leaves the output empty
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && !r14_v) |=> !r_out_vld)
        else $error("output transaction without source");

    // a stalled output transaction is not overwritten
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_ready) |=> (r_out_vld && $stable(r_out)))
        else $error("stalled output lost");

endmodule
